// ===== hdl/krf_pkg.sv =====
// ----------------------------------------------------------------------------
// krf_pkg
// Shared types, constants and key helpers for the keepalive replay filter.
// ----------------------------------------------------------------------------
package krf_pkg;

    localparam int KEY_W       = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic [KEY_W-1:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [KEY_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW    = 2'd0,
        ST_REPLAY = 2'd1,
        ST_NAN    = 2'd2
    } status_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;        // capture a new key, clear scan state
        logic rd_scan;     // read entry at idx
        logic wr_scan;     // write key or carried entry at idx, advance
        logic adv;         // advance idx without writing
        logic wr_append;   // write tail entry at idx, bump count
        logic clr_idx;     // restart idx for the prune copy
        logic rd_copy;     // read entry at idx + drop
        logic wr_copy;     // write copied entry at idx, advance
        logic set_keep;    // set count to the post-prune size
        logic set_replay;
        logic set_nan;
        logic out_load;    // load the result register
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic is_nan;
        logic at_end;      // idx has reached count
        logic lt;          // stored entry below key
        logic eq;          // stored entry equals key
        logic inserted;    // key already placed in this pass
        logic full;        // count above capacity
        logic copy_end;    // prune copy finished
    } sts_t;

    function automatic logic is_nan(input logic [KEY_W-1:0] bits);
        return ((bits & EXP_MASK) == EXP_MASK) && ((bits & FRAC_MASK) != '0);
    endfunction

    // Map a double bit pattern to an unsigned key of the same order.
    function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] b;
        b = (bits == SIGN_BIT) ? '0 : bits;
        return b[KEY_W-1] ? ~b : (b | SIGN_BIT);
    endfunction

endpackage

// ===== hdl/krf_datapath.sv =====
// ----------------------------------------------------------------------------
// krf_datapath
// Sorted key memory, scan index, carry register and result registers.
// ----------------------------------------------------------------------------
module krf_datapath #(
    parameter int CAPACITY = 100
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  krf_pkg::cmd_t                     cmd,
    output krf_pkg::sts_t                     sts,
    input  logic [krf_pkg::KEY_W-1:0]         key_bits,
    output logic [krf_pkg::STATUS_W-1:0]      res_status,
    output logic                              res_pruned,
    output logic [krf_pkg::COUNT_OUT_W-1:0]   res_count
);

    localparam int DEPTH  = CAPACITY + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DROP   = DEPTH / 2;
    localparam int KEEP   = DEPTH - DROP;
    localparam int EXT_W  = CNT_W + krf_pkg::COUNT_OUT_W;

    localparam logic [ADDR_W-1:0] DROP_A = ADDR_W'(DROP);
    localparam logic [ADDR_W-1:0] KEEP_A = ADDR_W'(KEEP);
    localparam logic [CNT_W-1:0]  KEEP_C = CNT_W'(KEEP);
    localparam logic [CNT_W-1:0]  FULL_C = CNT_W'(DEPTH);

    logic [krf_pkg::KEY_W-1:0] mem [DEPTH];
    logic [krf_pkg::KEY_W-1:0] rd_data_reg;

    logic [krf_pkg::KEY_W-1:0] key_reg, key_next;
    logic [krf_pkg::KEY_W-1:0] carry_reg, carry_next;
    logic                      nan_reg, nan_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      inserted_reg, inserted_next;
    krf_pkg::status_t          status_reg, status_next;
    logic                      pruned_reg, pruned_next;

    krf_pkg::status_t                 out_status_reg;
    logic                             out_pruned_reg;
    logic [krf_pkg::COUNT_OUT_W-1:0]  out_count_reg;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [krf_pkg::KEY_W-1:0] wr_data;
    logic [EXT_W-1:0]          count_ext;

    assign rd_en   = cmd.rd_scan | cmd.rd_copy;
    assign rd_addr = cmd.rd_copy ? ADDR_W'(idx_reg + DROP_A) : idx_reg;
    assign wr_en   = cmd.wr_scan | cmd.wr_append | cmd.wr_copy;
    assign wr_data = cmd.wr_copy ? rd_data_reg : (inserted_reg ? carry_reg : key_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        key_next      = key_reg;
        nan_next      = nan_reg;
        carry_next    = carry_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        inserted_next = inserted_reg;
        status_next   = status_reg;
        pruned_next   = pruned_reg;
        if (cmd.load) begin
            key_next      = krf_pkg::order_key(key_bits);
            nan_next      = krf_pkg::is_nan(key_bits);
            idx_next      = '0;
            inserted_next = 1'b0;
            status_next   = krf_pkg::ST_NEW;
            pruned_next   = 1'b0;
        end
        if (cmd.wr_scan) begin
            carry_next    = rd_data_reg;
            inserted_next = 1'b1;
            idx_next      = idx_reg + 1'b1;
        end
        if (cmd.adv || cmd.wr_copy) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.clr_idx) begin
            idx_next = '0;
        end
        if (cmd.wr_append) begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.set_keep) begin
            count_next  = KEEP_C;
            pruned_next = 1'b1;
        end
        if (cmd.set_replay) begin
            status_next = krf_pkg::ST_REPLAY;
        end
        if (cmd.set_nan) begin
            status_next = krf_pkg::ST_NAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            inserted_reg <= 1'b0;
            status_reg   <= krf_pkg::ST_NEW;
            pruned_reg   <= 1'b0;
        end else begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            inserted_reg <= inserted_next;
            status_reg   <= status_next;
            pruned_reg   <= pruned_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        nan_reg   <= nan_next;
        carry_reg <= carry_next;
    end

    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_pruned_reg <= pruned_reg;
            out_count_reg  <= count_ext[krf_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign res_status = out_status_reg;
    assign res_pruned = out_pruned_reg;
    assign res_count  = out_count_reg;

    assign sts.is_nan   = nan_reg;
    assign sts.at_end   = (CNT_W'(idx_reg) == count_reg);
    assign sts.lt       = (rd_data_reg < key_reg);
    assign sts.eq       = (rd_data_reg == key_reg);
    assign sts.inserted = inserted_reg;
    assign sts.full     = (count_reg == FULL_C);
    assign sts.copy_end = (idx_reg == KEEP_A);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("entry count above capacity plus one");

    a_load_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (count_reg < FULL_C))
        else $error("new key taken while set still over capacity");

    a_replay_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_replay |-> !inserted_reg)
        else $error("replay flagged after the store was modified");

    a_prune_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_keep |=> (count_reg == KEEP_C) && pruned_reg)
        else $error("prune did not leave the kept count");

endmodule

// ===== hdl/krf_ctrl.sv =====
// ----------------------------------------------------------------------------
// krf_ctrl
// Sequencer for scan, ordered insert and prune copy; owns the handshakes.
// ----------------------------------------------------------------------------
module krf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  krf_pkg::sts_t sts,
    output krf_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        IDLE     = 7'b0000001,
        SCAN_RD  = 7'b0000010,
        SCAN_CMP = 7'b0000100,
        CHECK    = 7'b0001000,
        COPY_RD  = 7'b0010000,
        COPY_WR  = 7'b0100000,
        FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = SCAN_RD;
                end
            end
            SCAN_RD: begin
                priority if (sts.is_nan) begin
                    cmd.set_nan = 1'b1;
                    state_next  = FINISH;
                end else if (sts.at_end) begin
                    cmd.wr_append = 1'b1;
                    state_next    = CHECK;
                end else begin
                    cmd.rd_scan = 1'b1;
                    state_next  = SCAN_CMP;
                end
            end
            SCAN_CMP: begin
                priority if (sts.inserted) begin
                    cmd.wr_scan = 1'b1;
                    state_next  = SCAN_RD;
                end else if (sts.eq) begin
                    cmd.set_replay = 1'b1;
                    state_next     = FINISH;
                end else if (sts.lt) begin
                    cmd.adv    = 1'b1;
                    state_next = SCAN_RD;
                end else begin
                    cmd.wr_scan = 1'b1;
                    state_next  = SCAN_RD;
                end
            end
            CHECK: begin
                if (sts.full) begin
                    cmd.clr_idx = 1'b1;
                    state_next  = COPY_RD;
                end else begin
                    state_next = FINISH;
                end
            end
            COPY_RD: begin
                if (sts.copy_end) begin
                    cmd.set_keep = 1'b1;
                    state_next   = FINISH;
                end else begin
                    cmd.rd_copy = 1'b1;
                    state_next  = COPY_WR;
                end
            end
            COPY_WR: begin
                cmd.wr_copy = 1'b1;
                state_next  = COPY_RD;
            end
            FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded over an untaken transaction");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.wr_scan, cmd.wr_append, cmd.wr_copy}))
        else $error("more than one memory write source in a cycle");

    a_accept_to_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == SCAN_RD))
        else $error("accepted transaction did not start a scan");

endmodule

// ===== hdl/keepalive_replay_filter_unit.sv =====
// ----------------------------------------------------------------------------
// keepalive_replay_filter_unit
// Anti-replay set of keepalive identifiers held sorted in a single-port-write,
// registered-read memory; reports new, replay or not-a-number per transaction.
// ----------------------------------------------------------------------------
// Flow: a new key is scanned against the set and inserted in order; a replay or
// not-a-number ends the scan early, and a prune copies keep = (CAPACITY + 2) / 2
// entries down. One transaction at a time; the scan reads each memory entry in
// SCAN_RD and compares it in SCAN_CMP.
// Reset: aresetn (synchronous, active low) empties the set at once; memory
// contents are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
module keepalive_replay_filter_unit #(
    parameter int CAPACITY = 100
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel: one identifier per transaction
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [krf_pkg::KEY_W-1:0]         s_key_bits,
    // result channel: one result per transaction
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [krf_pkg::STATUS_W-1:0]      m_status,
    output logic                              m_pruned,
    output logic [krf_pkg::COUNT_OUT_W-1:0]   m_stored_count
);

    // Command and status between sequencer and datapath.
    krf_pkg::cmd_t cmd;
    krf_pkg::sts_t sts;

    // Sequencer: accept, walk the sorted store, then hand the result to the
    // output register once the previous result has been taken. The input
    // side reopens as soon as the result register is loaded, so a new
    // transaction can start while the last result still waits downstream.
    krf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: map the identifier to an order-preserving key, scan upward
    // until a larger entry shows up, then ripple every later entry up by one
    // slot through the carry register. On overflow, move the upper half down.
    krf_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .key_bits   (s_key_bits),
        .res_status (m_status),
        .res_pruned (m_pruned),
        .res_count  (m_stored_count)
    );

endmodule
